/* rtl/sincos_pkg.sv */
// Shared types and fixed-point constants for the sine/cosine pipeline.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package sincos_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 24;
  localparam int OUT_FRAC_BITS_DEF   = 30;

  // width of the reduced angle, Q.32 signed
  localparam int RW = 36;

  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [34:0] TWO_PI     = 35'd26986075408;

  localparam logic signed [RW-1:0] HALF_PI    = 36'sd6746518852;
  localparam logic signed [RW-1:0] PI_Q       = 36'sd13493037704;
  localparam logic signed [RW-1:0] QUARTER_PI = 36'sd3373259426;

  localparam logic [19:0] S7_MAG  = 20'd852176;
  localparam logic [25:0] S5_MAG  = 26'd35791394;
  localparam logic [29:0] S3_MAG  = 30'd715827883;
  localparam logic [22:0] C6_MAG  = 23'd5965232;
  localparam logic [27:0] C4_MAG  = 28'd178956971;
  localparam logic [31:0] C2_MAG  = 32'd2147483648;
  localparam logic [32:0] ONE_MAG = 33'd4294967296;

  typedef struct packed {
    logic xneg;
    logic swap;
    logic sneg;
    logic cneg;
  } flags_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] xmag;
    flags_t      flg;
  } red_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] smag;
    logic [32:0] cmag;
    flags_t      flg;
  } poly_t;

endpackage

`default_nettype wire

/* rtl/sincos_reduce.sv */
// Angle reduction: turn count, remainder, fold to half circle, octant swap.
// Four register stages; depends on sincos_pkg.
`default_nettype none

module sincos_reduce
  import sincos_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_angle,
  output red_t        red
);

  localparam int ASH = 32 - ANGLE_FRAC_BITS;
  localparam int KSH = ANGLE_FRAC_BITS + 32;
  localparam int KW  = 63 - KSH;

  // stage A: turn product
  logic [31:0] a_mag;
  logic [61:0] a_kp_nxt;
  logic        a_valid_r;
  logic [31:0] a_ang_r;
  logic [61:0] a_kp_r;

  assign a_mag    = in_angle[31] ? (~in_angle + 32'd1) : in_angle;
  assign a_kp_nxt = a_mag * INV_TWO_PI;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      a_ang_r   <= in_angle;
      a_kp_r    <= a_kp_nxt;
    end
  end

  // stage B: remainder
  logic [62:0]          b_ksum;
  logic [KW-1:0]        b_kmag;
  logic [KW+34:0]       b_kt;
  logic signed [63:0]   b_ash;
  logic signed [63:0]   b_ktx;
  logic signed [63:0]   b_r64;
  logic signed [RW-1:0] b_r_nxt;
  logic                 b_valid_r;
  logic signed [RW-1:0] b_r_r;

  assign b_ksum  = {1'b0, a_kp_r} + (63'd1 << (KSH - 1));
  assign b_kmag  = b_ksum[62:KSH];
  assign b_kt    = b_kmag * TWO_PI;
  assign b_ash   = $signed({{32{a_ang_r[31]}}, a_ang_r}) <<< ASH;
  assign b_ktx   = $signed(64'(b_kt));
  assign b_r64   = a_ang_r[31] ? (b_ash + b_ktx) : (b_ash - b_ktx);
  assign b_r_nxt = b_r64[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
      b_r_r     <= b_r_nxt;
    end
  end

  // stage C: fold onto half circle
  logic signed [RW-1:0] c_r_nxt;
  logic                 c_cneg_nxt;
  logic                 c_valid_r;
  logic signed [RW-1:0] c_r_r;
  logic                 c_cneg_r;

  always_comb begin
    c_r_nxt    = b_r_r;
    c_cneg_nxt = 1'b0;
    if (b_r_r > HALF_PI) begin
      c_r_nxt    = PI_Q - b_r_r;
      c_cneg_nxt = 1'b1;
    end else if (b_r_r < -HALF_PI) begin
      c_r_nxt    = -PI_Q - b_r_r;
      c_cneg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
      c_r_r     <= c_r_nxt;
      c_cneg_r  <= c_cneg_nxt;
    end
  end

  // stage D: co-angle where the magnitude is above a quarter of pi
  logic signed [RW-1:0] d_x;
  logic [RW-1:0]        d_xabs;
  red_t                 red_nxt;
  red_t                 red_r;

  always_comb begin
    d_x = c_r_r;
    red_nxt.flg.swap = 1'b0;
    red_nxt.flg.sneg = 1'b0;
    if (c_r_r > QUARTER_PI) begin
      d_x = HALF_PI - c_r_r;
      red_nxt.flg.swap = 1'b1;
    end else if (c_r_r < -QUARTER_PI) begin
      d_x = HALF_PI + c_r_r;
      red_nxt.flg.swap = 1'b1;
      red_nxt.flg.sneg = 1'b1;
    end
    d_xabs           = d_x[RW-1] ? RW'(-d_x) : RW'(d_x);
    red_nxt.valid    = c_valid_r;
    red_nxt.xmag     = d_xabs[31:0];
    red_nxt.flg.xneg = d_x[RW-1];
    red_nxt.flg.cneg = c_cneg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r.valid <= 1'b0;
    end else if (en) begin
      red_r <= red_nxt;
    end
  end

  assign red = red_r;

endmodule

`default_nettype wire

/* rtl/sincos_poly.sv */
// Horner evaluation of the sine and cosine polynomials, at most two multiplies per stage.
// Five register stages on magnitudes; depends on sincos_pkg.
`default_nettype none

module sincos_poly
  import sincos_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  red_t  red,
  output poly_t pipe
);

  function automatic logic [33:0] qrnd(input logic [65:0] p);
    logic [65:0] s;
    s = p + (66'd1 << 31);
    return s[65:32];
  endfunction

  // stage D: x squared
  logic [63:0] d_p;
  logic [31:0] d_x2_nxt;
  logic        d_valid_r;
  logic [31:0] d_xmag_r;
  logic [31:0] d_x2_r;
  flags_t      d_flg_r;

  assign d_p      = red.xmag * red.xmag;
  assign d_x2_nxt = 32'(qrnd(66'(d_p)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= red.valid;
      d_xmag_r  <= red.xmag;
      d_x2_r    <= d_x2_nxt;
      d_flg_r   <= red.flg;
    end
  end

  // stage E: innermost terms
  logic [51:0] e_ps;
  logic [54:0] e_pc;
  logic [25:0] e_t1_nxt;
  logic [27:0] e_c1_nxt;
  logic        e_valid_r;
  logic [31:0] e_xmag_r;
  logic [31:0] e_x2_r;
  flags_t      e_flg_r;
  logic [25:0] e_t1_r;
  logic [27:0] e_c1_r;

  assign e_ps     = d_x2_r * S7_MAG;
  assign e_pc     = d_x2_r * C6_MAG;
  assign e_t1_nxt = S5_MAG - 26'(qrnd(66'(e_ps)));
  assign e_c1_nxt = C4_MAG - 28'(qrnd(66'(e_pc)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= d_valid_r;
      e_xmag_r  <= d_xmag_r;
      e_x2_r    <= d_x2_r;
      e_flg_r   <= d_flg_r;
      e_t1_r    <= e_t1_nxt;
      e_c1_r    <= e_c1_nxt;
    end
  end

  // stage F: middle terms, both negative, kept as magnitudes
  logic [57:0] f_ps;
  logic [59:0] f_pc;
  logic [29:0] f_t2_nxt;
  logic [31:0] f_c2_nxt;
  logic        f_valid_r;
  logic [31:0] f_xmag_r;
  logic [31:0] f_x2_r;
  flags_t      f_flg_r;
  logic [29:0] f_t2_r;
  logic [31:0] f_c2_r;

  assign f_ps     = e_x2_r * e_t1_r;
  assign f_pc     = e_x2_r * e_c1_r;
  assign f_t2_nxt = S3_MAG - 30'(qrnd(66'(f_ps)));
  assign f_c2_nxt = C2_MAG - 32'(qrnd(66'(f_pc)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= e_valid_r;
      f_xmag_r  <= e_xmag_r;
      f_x2_r    <= e_x2_r;
      f_flg_r   <= e_flg_r;
      f_t2_r    <= f_t2_nxt;
      f_c2_r    <= f_c2_nxt;
    end
  end

  // stage G: outer terms, cosine done here
  logic [61:0] g_ps;
  logic [63:0] g_pc;
  logic [32:0] g_t3_nxt;
  logic [32:0] g_cmag_nxt;
  logic        g_valid_r;
  logic [31:0] g_xmag_r;
  flags_t      g_flg_r;
  logic [32:0] g_t3_r;
  logic [32:0] g_cmag_r;

  assign g_ps       = f_x2_r * f_t2_r;
  assign g_pc       = f_x2_r * f_c2_r;
  assign g_t3_nxt   = ONE_MAG - 33'(qrnd(66'(g_ps)));
  assign g_cmag_nxt = ONE_MAG - 33'(qrnd(66'(g_pc)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (en) begin
      g_valid_r <= f_valid_r;
      g_xmag_r  <= f_xmag_r;
      g_flg_r   <= f_flg_r;
      g_t3_r    <= g_t3_nxt;
      g_cmag_r  <= g_cmag_nxt;
    end
  end

  // stage H: sine times x
  logic [64:0] h_ps;
  poly_t       pipe_nxt;
  poly_t       pipe_r;

  assign h_ps = g_xmag_r * g_t3_r;

  always_comb begin
    pipe_nxt.valid = g_valid_r;
    pipe_nxt.smag  = 32'(qrnd(66'(h_ps)));
    pipe_nxt.cmag  = g_cmag_r;
    pipe_nxt.flg   = g_flg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign pipe = pipe_r;

endmodule

`default_nettype wire

/* rtl/sincos_outbuf.sv */
// Sign restore, rounding and saturation to the output format, output word
// register and skid buffer. Depends on sincos_pkg.
`default_nettype none

module sincos_outbuf
  import sincos_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  poly_t       pipe,
  output logic        advance,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);

  localparam int SH = 32 - OUT_FRAC_BITS;
  localparam logic [OUT_FRAC_BITS+1:0] LIM = (OUT_FRAC_BITS + 2)'(1) << OUT_FRAC_BITS;

  function automatic logic [31:0] to_out(input logic neg, input logic [32:0] mag);
    logic [33:0]              s;
    logic [OUT_FRAC_BITS+1:0] q;
    logic [31:0]              m;
    s = {1'b0, mag} + (34'd1 << (SH - 1));
    q = s[33:SH];
    if (q > LIM) begin
      q = LIM;
    end
    m = 32'(q);
    return neg ? (32'd0 - m) : m;
  endfunction

  logic        sn_neg;
  logic        cs_neg;
  logic [32:0] sn_mag;
  logic [32:0] cs_mag;
  logic [63:0] res;

  always_comb begin
    if (pipe.flg.swap) begin
      sn_neg = pipe.flg.sneg;
      sn_mag = pipe.cmag;
      cs_neg = pipe.flg.xneg ^ pipe.flg.cneg;
      cs_mag = {1'b0, pipe.smag};
    end else begin
      sn_neg = pipe.flg.xneg;
      sn_mag = {1'b0, pipe.smag};
      cs_neg = pipe.flg.cneg;
      cs_mag = pipe.cmag;
    end
    res = {to_out(cs_neg, cs_mag), to_out(sn_neg, sn_mag)};
  end

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        skid_valid_r;
  logic [63:0] skid_data_r;
  logic        out_take;

  assign out_take = out_valid_r & out_tready;
  assign advance  = ~skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (pipe.valid) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* rtl/sincos_polynomial_octant.sv */
// Top level of the sine/cosine block: reduction, polynomial and output stages.
// Depends on sincos_pkg, sincos_reduce, sincos_poly and sincos_outbuf.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready   angle_rad, signed Q8.24
//   out_     master     out_tvalid/out_tready sine_value, cosine_value, signed Q2.30
//
// One angle per cycle while in_tready is high; 4 reduction stages, 5 multiply stages, output.
// The multiply chain of the polynomial, up to two multipliers per stage, sets the depth.
// Synchronous active-low reset clears the valid bits only.
// in_tready falls only while the skid word is held; the whole pipe then holds.
`default_nettype none

module sincos_polynomial_octant
  import sincos_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] angle_rad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] sine_value, [63:32] cosine_value
);

  logic  advance;
  red_t  red;
  poly_t pipe;

  assign in_tready = advance;

  sincos_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .in_valid(in_tvalid),
    .in_angle(in_tdata),
    .red     (red)
  );

  sincos_poly u_poly (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (advance),
    .red  (red),
    .pipe (pipe)
  );

  sincos_outbuf #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe      (pipe),
    .advance   (advance),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for sincos_polynomial_octant: Q8.24 angles in, Q2.30 sine/cosine out.
// Holds its own fixed-point predictor and checks every out word in order, stalled or not.
// Depends only on the RTL top level.
module tb_top;

  localparam int ANGLE_FRAC = 24;
  localparam int OUT_FRAC   = 30;
  localparam int OUT_SHIFT  = 32 - OUT_FRAC;

  localparam longint ONE_Q32       = 64'sd4294967296;
  localparam longint HALF_PI_Q32   = 64'sd6746518852;
  localparam longint PI_Q32        = 2 * HALF_PI_Q32;
  localparam longint TWO_PI_Q32    = 4 * HALF_PI_Q32;
  localparam longint QUARTER_PI_Q32 = HALF_PI_Q32 / 2;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

  localparam longint SIN_C3 = -64'sd715827883;
  localparam longint SIN_C5 = 64'sd35791394;
  localparam longint SIN_C7 = -64'sd852176;
  localparam longint COS_C2 = -64'sd2147483648;
  localparam longint COS_C4 = 64'sd178956971;
  localparam longint COS_C6 = -64'sd5965232;

  localparam int PI_Q824         = 52707179;
  localparam int QUARTER_PI_Q824 = 13176795;

  typedef struct packed {
    logic [31:0] cosine;
    logic [31:0] sine;
  } sincos_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  logic [31:0] angle_backlog[$];
  sincos_t     pending_sincos[$];
  int          send_idle_pct = 11;
  int          recv_idle_pct = 74;
  int          mismatch_count = 0;

  sincos_polynomial_octant dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] magnitude(longint v);
    logic [63:0] u;
    u = v;
    return (v < 0) ? -u : u;
  endfunction

  // product of two Q.32 values, rounded half away from zero
  function automatic longint mul_q32(longint a, longint b);
    logic        neg;
    logic [63:0] p;
    logic [63:0] r;
    neg = (a < 0) != (b < 0);
    p = magnitude(a) * magnitude(b);
    r = (p + 64'h8000_0000) >> 32;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sin_series(longint x);
    longint x2;
    longint t;
    x2 = mul_q32(x, x);
    t = SIN_C5 + mul_q32(x2, SIN_C7);
    t = SIN_C3 + mul_q32(x2, t);
    t = ONE_Q32 + mul_q32(x2, t);
    return mul_q32(x, t);
  endfunction

  function automatic longint cos_series(longint x);
    longint x2;
    longint t;
    x2 = mul_q32(x, x);
    t = COS_C4 + mul_q32(x2, COS_C6);
    t = COS_C2 + mul_q32(x2, t);
    return ONE_Q32 + mul_q32(x2, t);
  endfunction

  function automatic logic [31:0] round_to_out(longint v);
    logic [63:0] r;
    longint      s;
    r = (magnitude(v) + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (r > (64'd1 << OUT_FRAC)) begin
      r = 64'd1 << OUT_FRAC;
    end
    s = (v < 0) ? -longint'(r) : longint'(r);
    return s[31:0];
  endfunction

  function automatic sincos_t sincos_of(logic [31:0] raw);
    longint      ang;
    longint      turns;
    longint      r;
    longint      x;
    longint      sn;
    longint      cs;
    logic [63:0] turns_scaled;
    logic        flip_cos;
    sincos_t     res;
    ang = longint'(signed'(raw));
    turns_scaled = magnitude(ang) * INV_TWO_PI_Q32;
    turns = longint'((turns_scaled + (64'd1 << (ANGLE_FRAC + 31))) >> (ANGLE_FRAC + 32));
    if (ang < 0) begin
      turns = -turns;
    end
    r = (ang <<< (32 - ANGLE_FRAC)) - turns * TWO_PI_Q32;
    flip_cos = 1'b0;
    if (r > HALF_PI_Q32) begin
      r = PI_Q32 - r;
      flip_cos = 1'b1;
    end else if (r < -HALF_PI_Q32) begin
      r = -PI_Q32 - r;
      flip_cos = 1'b1;
    end
    if (r > QUARTER_PI_Q32) begin
      x = HALF_PI_Q32 - r;
      sn = cos_series(x);
      cs = sin_series(x);
    end else if (r < -QUARTER_PI_Q32) begin
      x = HALF_PI_Q32 + r;
      sn = -cos_series(x);
      cs = sin_series(x);
    end else begin
      sn = sin_series(r);
      cs = cos_series(r);
    end
    if (flip_cos) begin
      cs = -cs;
    end
    res.sine = round_to_out(sn);
    res.cosine = round_to_out(cs);
    return res;
  endfunction

  // random angles: full range, one turn, octant edges, odd multiples of pi
  task automatic push_random_angles(int count);
    int n;
    int a;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = $urandom();
        end
        3, 4, 5: begin
          a = int'($urandom_range(0, 2 * PI_Q824)) - PI_Q824;
        end
        6, 7: begin
          n = int'($urandom_range(0, 324)) - 162;
          a = n * QUARTER_PI_Q824 + int'($urandom_range(0, 64)) - 32;
        end
        default: begin
          n = 2 * int'($urandom_range(0, 39)) - 39;
          a = n * PI_Q824 + int'($urandom_range(0, 16)) - 8;
        end
      endcase
      angle_backlog.push_back(a);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_sincos.push_back(sincos_of(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (angle_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata <= angle_backlog.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sincos_t got;
    sincos_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_sincos.size() == 0) begin
          $error("out word %h arrived with no angle pending", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_sincos.pop_front();
          if (got.sine !== want.sine) begin
            $error("sine_value: expected %h, got %h", want.sine, got.sine);
            mismatch_count++;
          end
          if (got.cosine !== want.cosine) begin
            $error("cosine_value: expected %h, got %h", want.cosine, got.cosine);
            mismatch_count++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int directed_angles[$];
    directed_angles = '{0, 1, -1, int'(32'h7fff_ffff), int'(32'h8000_0000),
                        QUARTER_PI_Q824, QUARTER_PI_Q824 - 1, QUARTER_PI_Q824 + 1,
                        -QUARTER_PI_Q824, 2 * QUARTER_PI_Q824 - 1, -(2 * QUARTER_PI_Q824 - 1),
                        3 * QUARTER_PI_Q824, PI_Q824, PI_Q824 - 1, -PI_Q824,
                        2 * PI_Q824 - 1, 3 * PI_Q824, -3 * PI_Q824, 5 * PI_Q824,
                        -5 * PI_Q824, 39 * PI_Q824, 1 << ANGLE_FRAC,
                        int'(32'h5555_5555), int'(32'haaaa_aaaa)};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_angles[i]) begin
      angle_backlog.push_back(directed_angles[i]);
    end
    push_random_angles(340);
    while (angle_backlog.size() != 0) @(negedge clk);
    send_idle_pct = 74;
    recv_idle_pct = 11;
    push_random_angles(370);
    while (angle_backlog.size() != 0) @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_angles(370);
    while (angle_backlog.size() != 0 || in_tvalid || pending_sincos.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/sincos_pkg.sv
rtl/sincos_reduce.sv
rtl/sincos_poly.sv
rtl/sincos_outbuf.sv
rtl/sincos_polynomial_octant.sv
tb/sv/tb_top.sv
